// ===== rtl/mdsc_pkg.sv =====
// mdsc_pkg: types, codes and constants of the momentum descent step controller
// used by every module of the block; depends on nothing

package mdsc_pkg;

    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_GRAD = 2'd1,
        FUNC_OBJ  = 2'd2,
        FUNC_READ = 2'd3
    } mdsc_func_t;

    typedef enum logic [1:0] {
        STAT_RUNNING   = 2'd0,
        STAT_CONVERGED = 2'd1,
        STAT_STEP_MIN  = 2'd2,
        STAT_LIMIT     = 2'd3
    } mdsc_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GRAD_START,
        ST_GRAD_WAIT,
        ST_OBJ,
        ST_SWEEP,
        ST_SWEEP_TAIL,
        ST_READ,
        ST_READ_WAIT,
        ST_DONE
    } mdsc_state_t;

    typedef enum logic [1:0] {
        SWP_CLEAR,
        SWP_RESTORE,
        SWP_SAVE
    } mdsc_sweep_t;

    typedef struct packed {
        mdsc_func_t         func;
        logic [5:0]         element_index;
        logic signed [31:0] value;
    } mdsc_in_t;

    typedef struct packed {
        logic signed [31:0] position_value;
        mdsc_status_t       status;
        logic [30:0]        current_step;
    } mdsc_out_t;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] saved;
        logic signed [31:0] vel;
    } mdsc_word_t;

    typedef struct packed {
        logic [30:0] initial_step;
        logic [30:0] minimum_step;
        logic [30:0] minimum_improvement;
        logic [15:0] iteration_limit;
        logic [16:0] momentum_weight;
        logic [6:0]  length_in_use;
    } mdsc_cfg_t;

    typedef struct packed {
        logic [30:0]        step;
        logic signed [31:0] grad;
        logic [16:0]        weight;
        logic signed [31:0] vel;
        logic signed [31:0] pos;
    } mdsc_upd_op_t;

    typedef struct packed {
        logic signed [31:0] vel;
        logic signed [31:0] pos;
    } mdsc_upd_res_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 31;

    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_STEP        = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MINIMUM_STEP        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MINIMUM_IMPROVEMENT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ITERATION_LIMIT     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MOMENTUM_WEIGHT     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LENGTH_IN_USE       = 3'd5;

    localparam logic [16:0] ONE_Q16     = 17'h10000;
    localparam logic [2:0]  ACCEL_AFTER = 3'd5;

    localparam mdsc_cfg_t CFG_RESET = '{
        initial_step:        31'd65536,
        minimum_step:        31'd1,
        minimum_improvement: 31'd1,
        iteration_limit:     16'd1000,
        momentum_weight:     17'd0,
        length_in_use:       7'd64
    };

    // saturate to signed 32 bit
    function automatic logic signed [31:0] sat_q16(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (x < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/momentum_descent_step_controller.sv =====
// Momentum descent step controller. One transaction in gives one transaction out. A load
// writes an element in use, a position read reads one; a gradient element passes the
// memory read, the six-stage multiply and round pipeline and write-back; an objective value
// may restore or save the whole position vector, one element per cycle through the single
// read and single write port of the element memory. After reset the block clears the
// velocities and takes no input meanwhile; configuration writes are taken at any time.
// A finished result waits in the output register and the next input may be
// taken behind it.

module momentum_descent_step_controller #(
    parameter int VECTOR_LENGTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mdsc_pkg::mdsc_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mdsc_pkg::mdsc_out_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [mdsc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mdsc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int AW = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;

    mdsc_pkg::mdsc_cfg_t     cfg_reg, cfg_next;
    logic                    step_load;

    logic                    mem_rd_en;
    logic [AW-1:0]           mem_rd_addr;
    mdsc_pkg::mdsc_word_t    mem_rd_data;
    logic                    mem_wr_en;
    logic [AW-1:0]           mem_wr_addr;
    mdsc_pkg::mdsc_word_t    mem_wr_data;
    logic                    upd_start;
    mdsc_pkg::mdsc_upd_op_t  upd_op;
    logic                    upd_done;
    mdsc_pkg::mdsc_upd_res_t upd_res;

    always_comb begin
        cfg_next  = cfg_reg;
        step_load = 1'b0;
        if (cfg_wr_en) begin
            case (cfg_index)
                mdsc_pkg::REG_INITIAL_STEP: begin
                    cfg_next.initial_step = cfg_wdata[30:0];
                    step_load             = 1'b1;
                end
                mdsc_pkg::REG_MINIMUM_STEP:        cfg_next.minimum_step = cfg_wdata[30:0];
                mdsc_pkg::REG_MINIMUM_IMPROVEMENT: begin
                    cfg_next.minimum_improvement = cfg_wdata[30:0];
                end
                mdsc_pkg::REG_ITERATION_LIMIT:     cfg_next.iteration_limit = cfg_wdata[15:0];
                mdsc_pkg::REG_MOMENTUM_WEIGHT:     cfg_next.momentum_weight = cfg_wdata[16:0];
                mdsc_pkg::REG_LENGTH_IN_USE:       cfg_next.length_in_use = cfg_wdata[6:0];
                default:                           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= mdsc_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mdsc_elem_mem #(
        .DEPTH (VECTOR_LENGTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    mdsc_update u_update (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (upd_start),
        .op      (upd_op),
        .done    (upd_done),
        .res     (upd_res)
    );

    mdsc_ctrl #(
        .VECTOR_LENGTH (VECTOR_LENGTH),
        .AW            (AW)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg             (cfg_reg),
        .step_load       (step_load),
        .step_load_value (cfg_wdata[30:0]),
        .mem_rd_en       (mem_rd_en),
        .mem_rd_addr     (mem_rd_addr),
        .mem_rd_data     (mem_rd_data),
        .mem_wr_en       (mem_wr_en),
        .mem_wr_addr     (mem_wr_addr),
        .mem_wr_data     (mem_wr_data),
        .upd_start       (upd_start),
        .upd_op          (upd_op),
        .upd_done        (upd_done),
        .upd_res         (upd_res)
    );

endmodule

// ===== rtl/mdsc_elem_mem.sv =====
// mdsc_elem_mem: element memory holding position, saved position and velocity
// one write port, one read port with registered data; depends on mdsc_pkg

module mdsc_elem_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 aclk,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output mdsc_pkg::mdsc_word_t rd_data,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  mdsc_pkg::mdsc_word_t wr_data
);

    mdsc_pkg::mdsc_word_t mem_array [DEPTH];
    mdsc_pkg::mdsc_word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/mdsc_update.sv =====
// mdsc_update: six-stage momentum and position update for one gradient element
// v = round(w*v - (1-w)*round(step*g)), x = sat(x + v); depends on mdsc_pkg

module mdsc_update (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  mdsc_pkg::mdsc_upd_op_t  op,
    output logic                    done,
    output mdsc_pkg::mdsc_upd_res_t res
);

    localparam int STAGES = 6;

    logic [STAGES-1:0]  vld_reg, vld_next;
    logic [16:0]        w_eff;

    logic signed [63:0] prod_reg, prod_next;
    logic signed [49:0] wv1_reg, wv1_next, wv2_reg, wv3_reg;
    logic [16:0]        omw1_reg, omw1_next, omw2_reg;
    logic signed [31:0] pos1_reg, pos2_reg, pos3_reg, pos4_reg, pos5_reg, pos6_reg;
    logic signed [47:0] sg_reg, sg_next;
    logic signed [65:0] b_reg, b_next;
    logic signed [65:0] acc_reg, acc_next;
    logic signed [65:0] vel_rnd;
    logic signed [31:0] vel5_reg, vel5_next, vel6_reg;
    logic signed [32:0] pos_sum;
    logic signed [31:0] pos6_next;

    always_comb begin
        w_eff     = (op.weight > mdsc_pkg::ONE_Q16) ? mdsc_pkg::ONE_Q16 : op.weight;
        vld_next  = {vld_reg[STAGES-2:0], start};
        prod_next = $signed({1'b0, op.step}) * op.grad;
        wv1_next  = $signed({1'b0, w_eff}) * op.vel;
        omw1_next = mdsc_pkg::ONE_Q16 - w_eff;
        sg_next   = 48'((prod_reg + 64'sd32768) >>> 16);
        b_next    = $signed({1'b0, omw2_reg}) * sg_reg;
        acc_next  = $signed({{16{wv3_reg[49]}}, wv3_reg}) - b_reg;
        vel_rnd   = (acc_reg + 66'sd32768) >>> 16;
        vel5_next = mdsc_pkg::sat_q16(vel_rnd);
        pos_sum   = $signed({pos5_reg[31], pos5_reg}) + $signed({vel5_reg[31], vel5_reg});
        pos6_next = mdsc_pkg::sat_q16(66'(pos_sum));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        wv1_reg  <= wv1_next;
        omw1_reg <= omw1_next;
        pos1_reg <= op.pos;
        sg_reg   <= sg_next;
        wv2_reg  <= wv1_reg;
        omw2_reg <= omw1_reg;
        pos2_reg <= pos1_reg;
        b_reg    <= b_next;
        wv3_reg  <= wv2_reg;
        pos3_reg <= pos2_reg;
        acc_reg  <= acc_next;
        pos4_reg <= pos3_reg;
        vel5_reg <= vel5_next;
        pos5_reg <= pos4_reg;
        vel6_reg <= vel5_reg;
        pos6_reg <= pos6_next;
    end

    assign done = vld_reg[STAGES-1];
    assign res  = '{vel: vel6_reg, pos: pos6_reg};

endmodule

// ===== rtl/mdsc_ctrl.sv =====
// mdsc_ctrl: transaction sequencer, objective decision, vector sweeps, result register
// drives the element memory and the update pipeline; depends on mdsc_pkg

module mdsc_ctrl #(
    parameter int VECTOR_LENGTH = 64,
    parameter int AW            = 6
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  mdsc_pkg::mdsc_in_t      s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output mdsc_pkg::mdsc_out_t     m_data,
    input  mdsc_pkg::mdsc_cfg_t     cfg,
    input  logic                    step_load,
    input  logic [30:0]             step_load_value,
    output logic                    mem_rd_en,
    output logic [AW-1:0]           mem_rd_addr,
    input  mdsc_pkg::mdsc_word_t    mem_rd_data,
    output logic                    mem_wr_en,
    output logic [AW-1:0]           mem_wr_addr,
    output mdsc_pkg::mdsc_word_t    mem_wr_data,
    output logic                    upd_start,
    output mdsc_pkg::mdsc_upd_op_t  upd_op,
    input  logic                    upd_done,
    input  mdsc_pkg::mdsc_upd_res_t upd_res
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(VECTOR_LENGTH - 1);

    mdsc_pkg::mdsc_state_t  state_reg, state_next;
    mdsc_pkg::mdsc_in_t     item_reg, item_next;
    logic                   in_use_reg, in_use_next;
    logic signed [31:0]     res_pos_reg, res_pos_next;
    logic signed [31:0]     saved_reg, saved_next;
    mdsc_pkg::mdsc_sweep_t  mode_reg, mode_next;
    logic [AW-1:0]          cnt_reg, cnt_next;
    logic                   pend_reg, pend_next;
    logic [AW-1:0]          pend_addr_reg, pend_addr_next;
    logic [30:0]            step_reg, step_next;
    logic signed [31:0]     last_obj_reg, last_obj_next;
    logic [2:0]             grc_reg, grc_next;
    logic [15:0]            eval_reg, eval_next;
    logic                   base_reg, base_next;
    mdsc_pkg::mdsc_status_t status_reg, status_next;
    logic                   m_valid_reg, m_valid_next;
    mdsc_pkg::mdsc_out_t    m_data_reg, m_data_next;

    logic                   s_in_use;
    logic                   out_free;
    logic                   running;
    logic                   obj_worse;
    logic signed [32:0]     obj_drop;
    logic                   obj_small;
    logic                   obj_sweep;
    logic [30:0]            step_half;
    logic                   accel_room;
    logic [30:0]            step_double;
    logic [2:0]             grc_inc;
    logic [15:0]            eval_inc;
    mdsc_pkg::mdsc_word_t   sweep_word;

    assign s_in_use = ({1'b0, s_data.element_index} < cfg.length_in_use)
                   && (32'(s_data.element_index) < 32'(VECTOR_LENGTH));
    assign out_free = !m_valid_reg || m_ready;
    assign running  = (status_reg == mdsc_pkg::STAT_RUNNING);

    // objective decision terms
    assign obj_worse   = $signed(item_reg.value) > $signed(last_obj_reg);
    assign obj_drop    = $signed({last_obj_reg[31], last_obj_reg})
                       - $signed({item_reg.value[31], item_reg.value});
    assign obj_small   = obj_drop < $signed({2'b00, cfg.minimum_improvement});
    assign obj_sweep   = running && base_reg && (obj_worse || !obj_small);
    assign step_half   = {1'b0, step_reg[30:1]};
    assign accel_room  = {step_reg, 1'b0} < {1'b0, cfg.initial_step};
    assign step_double = step_reg[30] ? '1 : {step_reg[29:0], 1'b0};
    assign grc_inc     = grc_reg + 3'd1;
    assign eval_inc    = eval_reg + 16'd1;

    always_comb begin
        sweep_word = mem_rd_data;
        case (mode_reg)
            mdsc_pkg::SWP_SAVE: begin
                sweep_word.saved = mem_rd_data.pos;
            end
            mdsc_pkg::SWP_RESTORE: begin
                sweep_word.pos = mem_rd_data.saved;
                sweep_word.vel = '0;
            end
            default: begin
                sweep_word.vel = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mdsc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.func)
                        mdsc_pkg::FUNC_LOAD: state_next = mdsc_pkg::ST_DONE;
                        mdsc_pkg::FUNC_GRAD: state_next = mdsc_pkg::ST_GRAD_START;
                        mdsc_pkg::FUNC_OBJ:  state_next = mdsc_pkg::ST_OBJ;
                        mdsc_pkg::FUNC_READ: state_next = mdsc_pkg::ST_READ_WAIT;
                        default:             state_next = mdsc_pkg::ST_IDLE;
                    endcase
                end
            end
            mdsc_pkg::ST_GRAD_START: begin
                state_next = (in_use_reg && running) ? mdsc_pkg::ST_GRAD_WAIT
                                                     : mdsc_pkg::ST_DONE;
            end
            mdsc_pkg::ST_GRAD_WAIT: begin
                if (upd_done) begin
                    state_next = mdsc_pkg::ST_DONE;
                end
            end
            mdsc_pkg::ST_OBJ: begin
                state_next = obj_sweep ? mdsc_pkg::ST_SWEEP : mdsc_pkg::ST_DONE;
            end
            mdsc_pkg::ST_SWEEP: begin
                if (cnt_reg == LAST_ADDR) begin
                    state_next = mdsc_pkg::ST_SWEEP_TAIL;
                end
            end
            mdsc_pkg::ST_SWEEP_TAIL: begin
                state_next = (mode_reg == mdsc_pkg::SWP_CLEAR) ? mdsc_pkg::ST_IDLE
                                                               : mdsc_pkg::ST_READ;
            end
            mdsc_pkg::ST_READ:      state_next = mdsc_pkg::ST_READ_WAIT;
            mdsc_pkg::ST_READ_WAIT: state_next = mdsc_pkg::ST_DONE;
            mdsc_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = mdsc_pkg::ST_IDLE;
                end
            end
            default: state_next = mdsc_pkg::ST_IDLE;
        endcase
    end

    // outputs toward memory, update pipeline and input channel
    always_comb begin
        s_ready     = (state_reg == mdsc_pkg::ST_IDLE);
        mem_rd_en   = 1'b0;
        mem_rd_addr = AW'(item_reg.element_index);
        mem_wr_en   = 1'b0;
        mem_wr_addr = pend_addr_reg;
        mem_wr_data = sweep_word;
        upd_start   = 1'b0;
        upd_op      = '{step: step_reg, grad: item_reg.value, weight: cfg.momentum_weight,
                        vel: mem_rd_data.vel, pos: mem_rd_data.pos};
        case (state_reg)
            mdsc_pkg::ST_IDLE: begin
                mem_rd_en   = s_valid;
                mem_rd_addr = AW'(s_data.element_index);
                if (s_valid && s_data.func == mdsc_pkg::FUNC_LOAD && s_in_use) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = AW'(s_data.element_index);
                    mem_wr_data = '{pos: s_data.value, saved: s_data.value, vel: '0};
                end
            end
            mdsc_pkg::ST_GRAD_START: begin
                upd_start = in_use_reg && running;
            end
            mdsc_pkg::ST_GRAD_WAIT: begin
                mem_wr_en   = upd_done;
                mem_wr_addr = AW'(item_reg.element_index);
                mem_wr_data = '{pos: upd_res.pos, saved: saved_reg, vel: upd_res.vel};
            end
            mdsc_pkg::ST_SWEEP: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = cnt_reg;
                mem_wr_en   = pend_reg;
            end
            mdsc_pkg::ST_SWEEP_TAIL: begin
                mem_wr_en = pend_reg;
            end
            mdsc_pkg::ST_READ: begin
                mem_rd_en = 1'b1;
            end
            default: begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    // datapath and run state
    always_comb begin
        item_next      = item_reg;
        in_use_next    = in_use_reg;
        res_pos_next   = res_pos_reg;
        saved_next     = saved_reg;
        mode_next      = mode_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        step_next      = step_reg;
        last_obj_next  = last_obj_reg;
        grc_next       = grc_reg;
        eval_next      = eval_reg;
        base_next      = base_reg;
        status_next    = status_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        if (step_load && !base_reg) begin
            step_next = step_load_value;
        end

        case (state_reg)
            mdsc_pkg::ST_IDLE: begin
                if (s_valid) begin
                    item_next    = s_data;
                    in_use_next  = s_in_use;
                    res_pos_next = s_in_use ? s_data.value : '0;
                end
            end
            mdsc_pkg::ST_GRAD_START: begin
                saved_next   = mem_rd_data.saved;
                res_pos_next = in_use_reg ? mem_rd_data.pos : '0;
            end
            mdsc_pkg::ST_GRAD_WAIT: begin
                if (upd_done) begin
                    res_pos_next = upd_res.pos;
                end
            end
            mdsc_pkg::ST_OBJ: begin
                res_pos_next = in_use_reg ? mem_rd_data.pos : '0;
                cnt_next     = '0;
                pend_next    = 1'b0;
                mode_next    = obj_worse ? mdsc_pkg::SWP_RESTORE : mdsc_pkg::SWP_SAVE;
                if (running) begin
                    if (!base_reg) begin
                        last_obj_next = item_reg.value;
                        base_next     = 1'b1;
                    end else begin
                        eval_next = eval_inc;
                        if (obj_worse) begin
                            step_next = step_half;
                            if (step_half < cfg.minimum_step) begin
                                status_next = mdsc_pkg::STAT_STEP_MIN;
                            end
                        end else if (obj_small) begin
                            status_next = mdsc_pkg::STAT_CONVERGED;
                        end else begin
                            if (accel_room) begin
                                if (grc_inc >= mdsc_pkg::ACCEL_AFTER) begin
                                    grc_next  = '0;
                                    step_next = step_double;
                                end else begin
                                    grc_next = grc_inc;
                                end
                            end else begin
                                step_next = cfg.initial_step;
                            end
                            last_obj_next = item_reg.value;
                        end
                    end
                    if (status_next == mdsc_pkg::STAT_RUNNING
                        && eval_next >= cfg.iteration_limit) begin
                        status_next = mdsc_pkg::STAT_LIMIT;
                    end
                end
            end
            mdsc_pkg::ST_SWEEP: begin
                cnt_next       = cnt_reg + AW'(1);
                pend_next      = 1'b1;
                pend_addr_next = cnt_reg;
            end
            mdsc_pkg::ST_SWEEP_TAIL: begin
                pend_next = 1'b0;
            end
            mdsc_pkg::ST_READ_WAIT: begin
                res_pos_next = in_use_reg ? mem_rd_data.pos : '0;
            end
            mdsc_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{position_value: res_pos_reg, status: status_reg,
                                     current_step: step_reg};
                end
            end
            default: begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mdsc_pkg::ST_SWEEP;
            mode_reg     <= mdsc_pkg::SWP_CLEAR;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            step_reg     <= mdsc_pkg::CFG_RESET.initial_step;
            last_obj_reg <= '0;
            grc_reg      <= '0;
            eval_reg     <= '0;
            base_reg     <= 1'b0;
            status_reg   <= mdsc_pkg::STAT_RUNNING;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            step_reg     <= step_next;
            last_obj_reg <= last_obj_next;
            grc_reg      <= grc_next;
            eval_reg     <= eval_next;
            base_reg     <= base_next;
            status_reg   <= status_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        in_use_reg    <= in_use_next;
        res_pos_reg   <= res_pos_next;
        saved_reg     <= saved_next;
        pend_addr_reg <= pend_addr_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_accept_then_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a transaction is still in work");

    a_stop_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        status_reg != mdsc_pkg::STAT_RUNNING |=> status_reg == $past(status_reg))
        else $error("run status left a stopped state");

    a_update_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_done |-> state_reg == mdsc_pkg::ST_GRAD_WAIT)
        else $error("update result arrived outside the gradient wait");

    a_eval_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == mdsc_pkg::ST_OBJ && running && base_reg
        |=> eval_reg == $past(eval_reg) + 16'd1)
        else $error("objective evaluation not counted");

endmodule
